FILE: design/dssl_pkg.sv
// Package for the differential steering slew limiter: field widths, register
// indexes, opcodes and the constants of the rounded divide by the maximum angle.
// No dependencies.
`default_nettype none

package dssl_pkg;

  // Field and register widths.
  localparam int BASE_W   = 10;
  localparam int STEP_W   = 8;
  localparam int DIFF_W   = 8;
  localparam int LIMIT_W  = 15;
  localparam int ANGLE_W  = 16;
  localparam int SPEED_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Register reset values.
  localparam logic [BASE_W-1:0]  BASE_SPEED_RESET     = 10'd20;
  localparam logic [STEP_W-1:0]  SPEED_STEP_RESET     = 8'd2;
  localparam logic [DIFF_W-1:0]  MAX_DIFF_RESET       = 8'd10;
  localparam logic [LIMIT_W-1:0] STRAIGHT_LIMIT_RESET = 15'd1280;

  // Full-scale steering angle in Q8 (legal range 256 to 32767).
  localparam int MAX_ANGLE_Q8 = 5120;
  localparam int ROUND_BIAS   = MAX_ANGLE_Q8 / 2;

  // Magnitude of a 16-bit signed angle fits 16 unsigned bits.
  localparam int MAG_W = ANGLE_W;
  // Product |angle| * max_differential plus the rounding bias.
  localparam int NUM_W = MAG_W + DIFF_W;
  // Quotient bound: the divisor is at least 256.
  localparam int QUO_W = NUM_W - 8;

  // Exact division by a constant: floor(n / D) = (n * RECIP) >> DIV_SHIFT for
  // every n below 2**NUM_W, with RECIP = ceil(2**DIV_SHIFT / D).
  localparam int DIV_SHIFT = NUM_W + $clog2(MAX_ANGLE_Q8);
  localparam longint unsigned RECIP =
    ((64'd1 << DIV_SHIFT) + MAX_ANGLE_Q8 - 1) / MAX_ANGLE_Q8;
  localparam int RECIP_W = NUM_W + 1;
  localparam int MUL_W   = DIV_SHIFT + QUO_W;

  // Item opcodes.
  typedef enum logic {
    OP_ANGLE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_SPEED     = 3'd0,
    REG_SPEED_STEP     = 3'd1,
    REG_MAX_DIFF       = 3'd2,
    REG_STRAIGHT_LIMIT = 3'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: design/dssl_if.sv
// Channel interfaces of the differential steering slew limiter: input items,
// result items and configuration writes. Depends on dssl_pkg.
`default_nettype none

interface dssl_item_if import dssl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic                      line_found;
  logic signed [ANGLE_W-1:0] angle_q8;

  modport source (output valid, opcode, line_found, angle_q8, input ready);
  modport sink   (input valid, opcode, line_found, angle_q8, output ready);
endinterface

interface dssl_result_if import dssl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] target_right;
  logic signed [SPEED_W-1:0] target_left;
  logic signed [SPEED_W-1:0] desired_right;
  logic signed [SPEED_W-1:0] desired_left;
  logic                      turning;

  modport source (output valid, target_right, target_left, desired_right,
                  desired_left, turning, input ready);
  modport sink   (input valid, target_right, target_left, desired_right,
                  desired_left, turning, output ready);
endinterface

interface dssl_cfg_if import dssl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/differential_steering_slew_limiter.sv
// Differential steering slew limiter: an accepted input transaction is held
// in stage one and then registered into the result; one transaction per cycle,
// with the input held off only while stage one is full and a result waits.
// Stage one registers the magnitude product; stage two divides, clamps, mixes
// and slews. Synchronous active-high reset restores the register defaults, sets
// all four speeds to the default base speed and clears the turning flag.
`default_nettype none

module differential_steering_slew_limiter
  import dssl_pkg::*;
(
  input  wire            clk,
  input  wire            rst,
  dssl_item_if.sink      item,
  dssl_result_if.source  result,
  dssl_cfg_if.sink       cfg
);

  // Configuration registers. The user writes them only while the block is idle,
  // so nothing in flight ever sees a value change; the block does not enforce it.
  logic [BASE_W-1:0]  base_speed;
  logic [STEP_W-1:0]  speed_step;
  logic [DIFF_W-1:0]  max_differential;
  logic [LIMIT_W-1:0] straight_limit_q8;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed        <= BASE_SPEED_RESET;
      speed_step        <= SPEED_STEP_RESET;
      max_differential  <= MAX_DIFF_RESET;
      straight_limit_q8 <= STRAIGHT_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_BASE_SPEED:     base_speed        <= cfg.data[BASE_W-1:0];
        REG_SPEED_STEP:     speed_step        <= cfg.data[STEP_W-1:0];
        REG_MAX_DIFF:       max_differential  <= cfg.data[DIFF_W-1:0];
        REG_STRAIGHT_LIMIT: straight_limit_q8 <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake. The speed state doubles as the result register: it only
  // changes when the stage one transaction moves into it, which needs the
  // previous result to have been taken, so a waiting result never shifts.
  logic s1_valid;
  logic out_valid;
  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free   = !out_valid || result.ready;
  assign s1_fire    = s1_valid && out_free;
  assign item.ready = !s1_valid || out_free;
  assign in_fire    = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item.ready) begin
        s1_valid <= item.valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Stage one: magnitude of the angle, straight/turn decision and the
  // product with the maximum differential.
  logic signed [ANGLE_W:0] angle_ext;
  logic        [ANGLE_W:0] angle_abs;
  logic        [MAG_W-1:0] mag;
  logic        [NUM_W-1:0] prod_next;

  assign angle_ext = {item.angle_q8[ANGLE_W-1], item.angle_q8};
  assign angle_abs = angle_ext[ANGLE_W] ? (ANGLE_W+1)'(-angle_ext) : angle_ext;
  assign mag       = angle_abs[MAG_W-1:0];
  assign prod_next = NUM_W'(mag) * NUM_W'(max_differential);

  logic             s1_opcode;
  logic             s1_track;
  logic             s1_left;
  logic             s1_diff_on;
  logic [NUM_W-1:0] s1_prod;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode  <= item.opcode;
      s1_track   <= item.line_found;
      // Only a strictly positive angle steers left; zero takes the other side.
      s1_left    <= !item.angle_q8[ANGLE_W-1] && (item.angle_q8 != '0);
      s1_diff_on <= mag >= MAG_W'(straight_limit_q8);
      s1_prod    <= prod_next;
    end
  end

  // Stage two: rounded divide by the maximum angle through a constant
  // reciprocal, clamp to the maximum differential, then mix into the wheels.
  logic [NUM_W-1:0]  num;
  logic [MUL_W-1:0]  quo_full;
  logic [QUO_W-1:0]  quo;
  logic [DIFF_W-1:0] diff;

  assign num      = s1_prod + NUM_W'(ROUND_BIAS);
  assign quo_full = MUL_W'(num) * MUL_W'(RECIP_W'(RECIP));
  assign quo      = quo_full[DIV_SHIFT +: QUO_W];
  assign diff     = (quo > QUO_W'(max_differential)) ? max_differential
                                                     : quo[DIFF_W-1:0];

  logic signed [SPEED_W-1:0] base_s;
  logic signed [SPEED_W-1:0] diff_s;
  logic signed [SPEED_W-1:0] fast;
  logic signed [SPEED_W-1:0] slow;

  assign base_s = SPEED_W'(base_speed);
  assign diff_s = SPEED_W'(diff);
  assign fast   = base_s + diff_s;
  assign slow   = base_s - diff_s;

  // Moves a target toward its desired speed by at most the step.
  function automatic logic signed [SPEED_W-1:0] slew(
    input logic signed [SPEED_W-1:0] goal,
    input logic signed [SPEED_W-1:0] want,
    input logic        [STEP_W-1:0]  step
  );
    logic signed [SPEED_W:0] delta;
    logic signed [SPEED_W:0] lim;
    logic signed [SPEED_W:0] sum;
    delta = (SPEED_W+1)'(want) - (SPEED_W+1)'(goal);
    lim   = (SPEED_W+1)'({1'b0, step});
    if (delta > lim) begin
      delta = lim;
    end else if (delta < -lim) begin
      delta = -lim;
    end
    sum = (SPEED_W+1)'(goal) + delta;
    return sum[SPEED_W-1:0];
  endfunction

  // Speed state, which is also what the result transaction carries.
  logic signed [SPEED_W-1:0] want_right;
  logic signed [SPEED_W-1:0] want_left;
  logic signed [SPEED_W-1:0] goal_right;
  logic signed [SPEED_W-1:0] goal_left;
  logic                      turn_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      want_right <= SPEED_W'(BASE_SPEED_RESET);
      want_left  <= SPEED_W'(BASE_SPEED_RESET);
      goal_right <= SPEED_W'(BASE_SPEED_RESET);
      goal_left  <= SPEED_W'(BASE_SPEED_RESET);
      turn_flag  <= 1'b0;
    end else if (s1_fire) begin
      if (s1_opcode == OP_TICK) begin
        goal_right <= slew(goal_right, want_right, speed_step);
        goal_left  <= slew(goal_left, want_left, speed_step);
      end else if (s1_track) begin
        // An update without a track leaves everything as it was.
        turn_flag <= s1_diff_on;
        if (!s1_diff_on) begin
          want_right <= base_s;
          want_left  <= base_s;
        end else if (s1_left) begin
          want_right <= fast;
          want_left  <= slow;
        end else begin
          want_right <= slow;
          want_left  <= fast;
        end
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.target_right  = goal_right;
  assign result.target_left   = goal_left;
  assign result.desired_right = want_right;
  assign result.desired_left  = want_left;
  assign result.turning       = turn_flag;

  // The speed state only moves when a transaction leaves stage one.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(s1_fire) |->
      $stable(want_right) && $stable(want_left) &&
      $stable(goal_right) && $stable(goal_left) && $stable(turn_flag))
    else $error("speed state changed without a transaction");

  // Straight running always leaves both desired speeds equal.
  a_straight_equal: assert property (@(posedge clk) disable iff (rst)
    !turn_flag |-> want_right == want_left)
    else $error("desired speeds differ while not turning");

  // An angle update never touches the motor targets.
  a_angle_keeps_targets: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(s1_fire) && $past(s1_opcode == OP_ANGLE) |->
      $stable(goal_right) && $stable(goal_left))
    else $error("motor target moved on an angle update");

endmodule

`default_nettype wire
